// ===== src/mgw_pkg.sv =====
package mgw_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int MAX_GLYPH     = 64;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR  = 8'h2C;

  localparam logic [2:0] REG_FG_COLOR     = 3'd0;
  localparam logic [2:0] REG_BG_COLOR     = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X     = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd3;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd4;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd5;

  localparam logic [4:0] START_LAST_IDX = 5'd10;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_PIX   = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [8:0]  x1;
    logic [8:0]  x2;
    logic [8:0]  y1;
    logic [8:0]  y2;
    logic [7:0]  bits;
    logic [3:0]  npix;
    logic        done;
    logic [15:0] fg;
    logic [15:0] bg;
  } job_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [15:0] wdata;
  } cfg_wr_t;

endpackage

// ===== src/mgw_in_if.sv =====
interface mgw_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] bitmap_byte;

  modport source (output valid, output command, output bitmap_byte, input ready);
  modport sink (input valid, input command, input bitmap_byte, output ready);
endinterface

// ===== src/mgw_out_if.sv =====
interface mgw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_run;
  logic       glyph_done;

  modport source (output valid, output out_byte, output is_data, output last_of_run,
                  output glyph_done, input ready);
  modport sink (input valid, input out_byte, input is_data, input last_of_run,
                input glyph_done, output ready);
endinterface

// ===== src/mgw_front.sv =====
module mgw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  mgw_pkg::cfg_wr_t cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_command,
  input  logic [7:0]      in_bitmap_byte,
  input  logic            q_full,
  output logic            q_push,
  output mgw_pkg::job_t   q_job
);

  logic [15:0] fg_r, bg_r;
  logic [7:0]  ox_r;
  logic [8:0]  oy_r;
  logic [6:0]  gw_r, gh_r;

  logic        active_r, active_nxt;
  logic [6:0]  row_r, row_nxt;
  logic [6:0]  cb_r, cb_nxt;

  logic        accept;
  logic [9:0]  x2_w, y2_w;
  logic        win_ok;
  logic [6:0]  diff;
  logic [3:0]  npix;
  logic [7:0]  cb_add;
  logic        wrap;
  logic [6:0]  row_inc;
  logic        glyph_end;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 16'hFFFF;
      bg_r <= 16'h0000;
      ox_r <= 8'd0;
      oy_r <= 9'd0;
      gw_r <= 7'd8;
      gh_r <= 7'd16;
    end else if (cfg.we) begin
      case (cfg.index)
        mgw_pkg::REG_FG_COLOR:     fg_r <= cfg.wdata;
        mgw_pkg::REG_BG_COLOR:     bg_r <= cfg.wdata;
        mgw_pkg::REG_ORIGIN_X:     ox_r <= cfg.wdata[7:0];
        mgw_pkg::REG_ORIGIN_Y:     oy_r <= cfg.wdata[8:0];
        mgw_pkg::REG_GLYPH_WIDTH:  gw_r <= cfg.wdata[6:0];
        mgw_pkg::REG_GLYPH_HEIGHT: gh_r <= cfg.wdata[6:0];
        default: ;
      endcase
    end
  end

  assign x2_w = {2'b00, ox_r} + {3'b000, gw_r} - 10'd1;
  assign y2_w = {1'b0, oy_r} + {3'b000, gh_r} - 10'd1;

  assign win_ok = (gw_r != 7'd0) && (gh_r != 7'd0) &&
                  ({1'b0, gw_r} <= 8'(mgw_pkg::MAX_GLYPH)) &&
                  ({1'b0, gh_r} <= 8'(mgw_pkg::MAX_GLYPH)) &&
                  ({3'b000, ox_r} < 11'(mgw_pkg::SCREEN_WIDTH)) &&
                  ({2'b00, oy_r} < 11'(mgw_pkg::SCREEN_HEIGHT)) &&
                  ({1'b0, x2_w} < 11'(mgw_pkg::SCREEN_WIDTH)) &&
                  ({1'b0, y2_w} < 11'(mgw_pkg::SCREEN_HEIGHT));

  assign diff    = gw_r - cb_r;
  assign npix    = (cb_r >= gw_r) ? 4'd0 : ((diff > 7'd8) ? 4'd8 : diff[3:0]);
  assign cb_add  = {1'b0, cb_r} + 8'd8;
  assign wrap    = cb_add >= {1'b0, gw_r};
  assign row_inc = row_r + 7'd1;
  assign glyph_end = wrap && ((row_inc == 7'd0) || (row_inc >= gh_r));

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    cb_nxt     = cb_r;
    q_push     = 1'b0;
    q_job.kind = mgw_pkg::KIND_PIX;
    q_job.x1   = {1'b0, ox_r};
    q_job.x2   = x2_w[8:0];
    q_job.y1   = oy_r;
    q_job.y2   = y2_w[8:0];
    q_job.bits = in_bitmap_byte;
    q_job.npix = npix;
    q_job.done = glyph_end;
    q_job.fg   = fg_r;
    q_job.bg   = bg_r;
    if (accept) begin
      if (!in_command) begin
        active_nxt = win_ok;
        row_nxt    = 7'd0;
        cb_nxt     = 7'd0;
        q_push     = win_ok;
        q_job.kind = mgw_pkg::KIND_START;
      end else if (active_r) begin
        q_push = npix != 4'd0;
        if (wrap) begin
          cb_nxt  = 7'd0;
          row_nxt = glyph_end ? 7'd0 : row_inc;
          if (glyph_end) begin
            active_nxt = 1'b0;
          end
        end else begin
          cb_nxt = cb_add[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      row_r    <= 7'd0;
      cb_r     <= 7'd0;
    end else begin
      active_r <= active_nxt;
      row_r    <= row_nxt;
      cb_r     <= cb_nxt;
    end
  end

endmodule

// ===== src/mgw_fifo.sv =====
module mgw_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mgw_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mgw_pkg::job_t head_job
);

  mgw_pkg::job_t                    mem_r [mgw_pkg::QDEPTH];
  logic [mgw_pkg::QPTR_W-1:0]       wp_r, wp_nxt;
  logic [mgw_pkg::QPTR_W-1:0]       rp_r, rp_nxt;
  logic [mgw_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full       = cnt_r == mgw_pkg::QCNT_W'(mgw_pkg::QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == mgw_pkg::QPTR_W'(mgw_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == mgw_pkg::QPTR_W'(mgw_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/mgw_back.sv =====
module mgw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  mgw_pkg::job_t job,
  output logic          job_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_is_data,
  output logic          out_last_of_run,
  output logic          out_glyph_done
);

  logic [4:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        data_r, data_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;

  logic        advance, emit, at_last;
  logic [4:0]  last_idx;
  logic [2:0]  pix;
  logic [15:0] color;
  logic [7:0]  sel_byte;
  logic        sel_data;

  assign advance  = !ov_r || out_ready;
  assign emit     = job_valid && advance;
  assign last_idx = (job.kind == mgw_pkg::KIND_START) ? mgw_pkg::START_LAST_IDX
                                                      : {job.npix, 1'b0} - 5'd1;
  assign at_last  = idx_r == last_idx;
  assign job_pop  = emit && at_last;
  assign pix      = idx_r[3:1];
  assign color    = job.bits[3'd7 - pix] ? job.fg : job.bg;

  always_comb begin
    sel_byte = 8'h00;
    sel_data = 1'b1;
    if (job.kind == mgw_pkg::KIND_START) begin
      case (idx_r)
        5'd0:    begin sel_byte = mgw_pkg::CMD_COL_SET; sel_data = 1'b0; end
        5'd1:    sel_byte = {7'd0, job.x1[8]};
        5'd2:    sel_byte = job.x1[7:0];
        5'd3:    sel_byte = {7'd0, job.x2[8]};
        5'd4:    sel_byte = job.x2[7:0];
        5'd5:    begin sel_byte = mgw_pkg::CMD_ROW_SET; sel_data = 1'b0; end
        5'd6:    sel_byte = {7'd0, job.y1[8]};
        5'd7:    sel_byte = job.y1[7:0];
        5'd8:    sel_byte = {7'd0, job.y2[8]};
        5'd9:    sel_byte = job.y2[7:0];
        default: begin sel_byte = mgw_pkg::CMD_MEM_WR; sel_data = 1'b0; end
      endcase
    end else begin
      sel_byte = idx_r[0] ? color[7:0] : color[15:8];
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    byte_nxt = byte_r;
    data_nxt = data_r;
    last_nxt = last_r;
    done_nxt = done_r;
    if (advance) begin
      ov_nxt = emit;
    end
    if (emit) begin
      idx_nxt  = at_last ? 5'd0 : idx_r + 5'd1;
      byte_nxt = sel_byte;
      data_nxt = sel_data;
      last_nxt = at_last;
      done_nxt = at_last && (job.kind == mgw_pkg::KIND_PIX) && job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 5'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

  assign out_valid       = ov_r;
  assign out_byte        = byte_r;
  assign out_is_data     = data_r;
  assign out_last_of_run = last_r;
  assign out_glyph_done  = done_r;

endmodule

// ===== src/mono_glyph_to_rgb565_writer.sv =====
// The first result byte of an item passes through the job queue and then the output
// register before it can transfer.
// A valid start item yields 11 bytes, a bitmap byte 2 bytes per pixel (up to 16),
// one byte per cycle while out_ready does not stall the output.
// A 2-entry job queue decouples input acceptance from byte emission.
// Synchronous active-low reset restores register defaults and clears glyph state,
// the queue and the output register; ready is high the cycle after reset.
module mono_glyph_to_rgb565_writer (
  input  logic         clk,
  input  logic         rst_n,
  mgw_in_if.sink       in_ch,
  mgw_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  mgw_pkg::cfg_wr_t cfg;
  mgw_pkg::job_t    push_job, head_job;
  logic             q_full, q_push, head_valid, job_pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  mgw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (in_ch.command),
    .in_bitmap_byte (in_ch.bitmap_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  mgw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  mgw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (head_valid),
    .job             (head_job),
    .job_pop         (job_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_byte        (out_ch.out_byte),
    .out_is_data     (out_ch.is_data),
    .out_last_of_run (out_ch.last_of_run),
    .out_glyph_done  (out_ch.glyph_done)
  );

endmodule

// ===== src/mgw_checker.sv =====
module mgw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       last_of_run,
  input logic       glyph_done
);

  // result held until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result dropped or changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && glyph_done |-> last_of_run && is_data)
    else $error("glyph_done on a byte that is not the last pixel byte");

  a_cmd_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_data |->
      out_byte == mgw_pkg::CMD_COL_SET || out_byte == mgw_pkg::CMD_ROW_SET ||
      out_byte == mgw_pkg::CMD_MEM_WR)
    else $error("unknown command byte");

  a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_data && last_of_run |-> out_byte == mgw_pkg::CMD_MEM_WR)
    else $error("start run ends on a byte other than memory write");

endmodule

bind mono_glyph_to_rgb565_writer mgw_checker u_mgw_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .is_data     (out_ch.is_data),
  .last_of_run (out_ch.last_of_run),
  .glyph_done  (out_ch.glyph_done)
);
